// ===== design/shell_command_safety_checker_top_macros.svh =====
// assertion macros used by the scan module
`ifndef SHELL_COMMAND_SAFETY_CHECKER_TOP_MACROS_SVH
`define SHELL_COMMAND_SAFETY_CHECKER_TOP_MACROS_SVH

// property checked on every rising clock edge outside reset
`define SCC_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error(msg);

// condition that must never be seen outside reset
`define SCC_ASSERT_NEVER(label, cond, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) \
    else $error(msg);

`endif

// ===== design/scc_pkg.sv =====
// types, constants and helpers for the shell command safety checker
package scc_pkg;

  localparam int unsigned PosBits = 16;
  localparam int unsigned OutBits = 16;
  localparam logic [PosBits-1:0] PosMax = {PosBits{1'b1}};

  localparam logic [7:0] ChDollar    = 8'h24;
  localparam logic [7:0] ChBackquote = 8'h60;
  localparam logic [7:0] ChSemicolon = 8'h3B;
  localparam logic [7:0] ChPipe      = 8'h7C;
  localparam logic [7:0] ChAmpersand = 8'h26;
  localparam logic [7:0] ChNewline   = 8'h0A;
  localparam logic [7:0] ChDquote    = 8'h22;
  localparam logic [7:0] ChSquote    = 8'h27;
  localparam logic [7:0] ChBackslash = 8'h5C;
  localparam logic [7:0] ChGreater   = 8'h3E;
  localparam logic [7:0] ChLess      = 8'h3C;
  localparam logic [7:0] ChCaret     = 8'h5E;

  typedef enum logic {
    ModeUnix    = 1'b0,
    ModeWindows = 1'b1
  } shell_mode_e;

  typedef enum logic [1:0] {
    QuoteNone   = 2'd0,
    QuoteSingle = 2'd1,
    QuoteDouble = 2'd2
  } quote_e;

  typedef struct packed {
    quote_e             quote;
    logic               skip;
    logic               after_bs;
    logic               after_caret;
    logic [PosBits-1:0] pos;
    logic               found;
    logic [PosBits-1:0] first_pos;
  } scan_state_t;

  typedef struct packed {
    logic               unsafe;
    logic [OutBits-1:0] pos;
  } result_t;

  function automatic logic [OutBits-1:0] clip_pos(logic [PosBits-1:0] p);
    logic [PosBits+OutBits-1:0] wide;
    logic [PosBits+OutBits-1:0] lim;
    wide = {{OutBits{1'b0}}, p};
    lim  = {{PosBits{1'b0}}, {OutBits{1'b1}}};
    if (wide > lim) begin
      return {OutBits{1'b1}};
    end
    return wide[OutBits-1:0];
  endfunction

endpackage

// ===== design/scc_in_stage.sv =====
// input register holding one byte item ahead of the scan
module scc_in_stage (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] char_byte_i,
  input  logic       last_byte_i,
  input  logic       take_i,
  output logic       valid_o,
  output logic [7:0] char_o,
  output logic       last_o
);
  logic       valid_q, valid_d;
  logic [7:0] char_q;
  logic       last_q;
  logic       accept;

  assign in_ready_o = !valid_q || take_i;
  assign accept     = in_valid_i && in_ready_o;

  always_comb begin
    valid_d = valid_q;
    if (accept) begin
      valid_d = 1'b1;
    end else if (take_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      char_q <= char_byte_i;
      last_q <= last_byte_i;
    end
  end

  assign valid_o = valid_q;
  assign char_o  = char_q;
  assign last_o  = last_q;
endmodule

// ===== design/scc_scan.sv =====
// scan state registers and the per-byte quote and hazard decode
`include "shell_command_safety_checker_top_macros.svh"

module scc_scan (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  scc_pkg::shell_mode_e mode_i,
  input  logic                 valid_i,
  input  logic [7:0]           char_i,
  input  logic                 last_i,
  input  logic                 space_i,
  output logic                 take_o,
  output logic                 res_valid_o,
  output scc_pkg::result_t     res_o
);
  import scc_pkg::*;

  scan_state_t        st_q, st_d, nx;
  logic [PosBits-1:0] p;
  logic               esc;
  logic               advance;

  assign advance = valid_i && space_i;
  assign take_o  = advance;
  assign p       = (st_q.pos != PosMax) ? st_q.pos + 1'b1 : st_q.pos;

  always_comb begin
    nx     = st_q;
    nx.pos = p;
    esc    = 1'b0;
    if (!st_q.found) begin
      if (st_q.skip) begin
        nx.skip = 1'b0;
      end else if (st_q.after_caret) begin
        nx.after_caret = 1'b0;
        if (char_i == ChDquote) begin
          nx.found     = 1'b1;
          nx.first_pos = (st_q.quote != QuoteNone) ? p - 1'b1 : p;
        end
      end else begin
        esc         = st_q.after_bs;
        nx.after_bs = 1'b0;
        if (!(esc && char_i == ChDquote)) begin
          if (mode_i == ModeUnix) begin
            unique case (char_i)
              ChDollar, ChBackquote: begin
                if (st_q.quote != QuoteSingle) begin
                  nx.found     = 1'b1;
                  nx.first_pos = p;
                end
              end
              ChSemicolon, ChPipe, ChAmpersand, ChNewline: begin
                if (st_q.quote != QuoteSingle && !last_i) begin
                  nx.found     = 1'b1;
                  nx.first_pos = p;
                end
              end
              ChDquote: begin
                if (st_q.quote == QuoteNone) begin
                  nx.quote = QuoteDouble;
                end else if (st_q.quote == QuoteDouble) begin
                  nx.quote = QuoteNone;
                end
              end
              ChSquote: begin
                if (st_q.quote == QuoteNone) begin
                  nx.quote = QuoteSingle;
                end else if (st_q.quote == QuoteSingle) begin
                  nx.quote = QuoteNone;
                end
              end
              ChBackslash: begin
                if (last_i) begin
                  nx.found     = 1'b1;
                  nx.first_pos = p;
                end else if (st_q.quote != QuoteSingle) begin
                  nx.skip = 1'b1;
                end
              end
              default: begin
              end
            endcase
          end else begin
            unique case (char_i)
              ChGreater, ChLess, ChPipe, ChAmpersand, ChNewline: begin
                if (st_q.quote == QuoteNone && !last_i) begin
                  nx.found     = 1'b1;
                  nx.first_pos = p;
                end
              end
              ChBackslash: begin
                if (!last_i) begin
                  nx.after_bs = 1'b1;
                end
              end
              ChDquote: begin
                nx.quote = (st_q.quote == QuoteDouble) ? QuoteNone : QuoteDouble;
              end
              ChCaret: begin
                if (!last_i) begin
                  nx.after_caret = 1'b1;
                end
              end
              default: begin
              end
            endcase
          end
        end
      end
    end
  end

  always_comb begin
    st_d = st_q;
    if (advance) begin
      if (last_i) begin
        st_d = '{quote: QuoteNone, pos: '0, first_pos: '0, default: 1'b0};
      end else begin
        st_d = nx;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= '{quote: QuoteNone, pos: '0, first_pos: '0, default: 1'b0};
    end else begin
      st_q <= st_d;
    end
  end

  assign res_valid_o = advance && last_i;

  always_comb begin
    res_o = '0;
    if (nx.found) begin
      res_o.unsafe = 1'b1;
      res_o.pos    = clip_pos(nx.first_pos);
    end else if (nx.quote != QuoteNone) begin
      res_o.unsafe = 1'b1;
      res_o.pos    = clip_pos(p);
    end
  end

  `SCC_ASSERT(a_clear_after_last, advance && last_i |=> st_q.pos == '0 && !st_q.found,
    "scan state not cleared after final byte")
  `SCC_ASSERT(a_finding_holds,
    st_q.found && !(advance && last_i) |=> st_q.found && $stable(st_q.first_pos),
    "finding lost before final byte")
  `SCC_ASSERT(a_lookback_onehot, $onehot0({st_q.skip, st_q.after_bs, st_q.after_caret}),
    "more than one look-back flag pending")
endmodule

// ===== design/scc_out_stage.sv =====
// result register between the scan and the result channel
module scc_out_stage (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         load_i,
  input  scc_pkg::result_t             res_i,
  output logic                         space_o,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic                         is_unsafe_o,
  output logic [scc_pkg::OutBits-1:0]  unsafe_position_o
);
  import scc_pkg::*;

  logic    valid_q, valid_d;
  result_t res_q;

  assign space_o = !valid_q || out_ready_i;

  always_comb begin
    valid_d = valid_q;
    if (load_i) begin
      valid_d = 1'b1;
    end else if (out_ready_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      res_q <= res_i;
    end
  end

  assign out_valid_o       = valid_q;
  assign is_unsafe_o       = res_q.unsafe;
  assign unsafe_position_o = res_q.pos;
endmodule

// ===== design/shell_command_safety_checker_top.sv =====
// top level of the shell command safety checker
//
//  channel | direction | handshake                  | payload
//  cfg     | in        | cfg_valid_i / cfg_ready_o  | cfg_shell_mode_i
//  in      | in        | in_valid_i / in_ready_o    | char_byte_i, last_byte_i
//  out     | out       | out_valid_o / out_ready_i  | is_unsafe_o, unsafe_position_o
//
// one byte item per cycle while the result channel does not stall; a verdict passes from its final
// byte through the input register and the combinational scan decode into the result register
// reset clears the scan state, both stage valids and selects unix rules
// a stalled result holds the scan, and the input register then fills and drops ready
module shell_command_safety_checker_top (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_valid_i,
  output logic                        cfg_ready_o,
  input  logic                        cfg_shell_mode_i,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic [7:0]                  char_byte_i,
  input  logic                        last_byte_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic                        is_unsafe_o,
  output logic [scc_pkg::OutBits-1:0] unsafe_position_o
);
  import scc_pkg::*;

  shell_mode_e mode_q, mode_d;
  logic        take;
  logic        stage_valid;
  logic [7:0]  stage_char;
  logic        stage_last;
  logic        space;
  logic        res_valid;
  result_t     res;

  assign cfg_ready_o = 1'b1;
  assign mode_d      = cfg_valid_i ? shell_mode_e'(cfg_shell_mode_i) : mode_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= ModeUnix;
    end else begin
      mode_q <= mode_d;
    end
  end

  scc_in_stage u_in_stage (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .char_byte_i (char_byte_i),
    .last_byte_i (last_byte_i),
    .take_i      (take),
    .valid_o     (stage_valid),
    .char_o      (stage_char),
    .last_o      (stage_last)
  );

  scc_scan u_scan (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .mode_i      (mode_q),
    .valid_i     (stage_valid),
    .char_i      (stage_char),
    .last_i      (stage_last),
    .space_i     (space),
    .take_o      (take),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  scc_out_stage u_out_stage (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .load_i            (res_valid),
    .res_i             (res),
    .space_o           (space),
    .out_valid_o       (out_valid_o),
    .out_ready_i       (out_ready_i),
    .is_unsafe_o       (is_unsafe_o),
    .unsafe_position_o (unsafe_position_o)
  );
endmodule

// ===== test/testbench.sv =====
// testbench for the shell command safety checker: directed table and random strings
`timescale 1ns / 1ps

module testbench;
  import scc_pkg::*;

  localparam int unsigned SettleCycles  = 6;
  localparam int unsigned WatchdogLimit = 4000;
  localparam int unsigned PhaseBytes    = 400;

  typedef enum logic { RowByte, RowMode } row_kind_e;

  typedef struct {
    row_kind_e   kind;
    shell_mode_e mode;
    logic [7:0]  ch;
    logic        last;
    logic        typed;
    result_t     verdict;
  } step_row_t;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                cfg_valid_i = 1'b0;
  logic                cfg_ready_o;
  logic                cfg_shell_mode_i = 1'b0;
  logic                in_valid_i = 1'b0;
  logic                in_ready_o;
  logic [7:0]          char_byte_i = 8'h61;
  logic                last_byte_i = 1'b0;
  logic                out_valid_o;
  logic                out_ready_i = 1'b0;
  logic                is_unsafe_o;
  logic [OutBits-1:0]  unsafe_position_o;

  // verdict typed into the table travels beside the item
  logic                item_typed = 1'b0;
  result_t             item_verdict = '0;

  int unsigned         gap_pct = 0;
  int unsigned         stall_pct = 0;
  int unsigned         errors = 0;
  shell_mode_e         rules = ModeUnix;
  scan_state_t         scan = '0;
  result_t             verdict_q[$];
  step_row_t           step_table[$];

  shell_command_safety_checker_top i_dut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_valid_i       (cfg_valid_i),
    .cfg_ready_o       (cfg_ready_o),
    .cfg_shell_mode_i  (cfg_shell_mode_i),
    .in_valid_i        (in_valid_i),
    .in_ready_o        (in_ready_o),
    .char_byte_i       (char_byte_i),
    .last_byte_i       (last_byte_i),
    .out_valid_o       (out_valid_o),
    .out_ready_i       (out_ready_i),
    .is_unsafe_o       (is_unsafe_o),
    .unsafe_position_o (unsafe_position_o)
  );

  always #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    out_ready_i <= ($urandom_range(99) >= stall_pct);
  end

  function automatic void flag_at(logic [PosBits-1:0] p);
    scan.found     = 1'b1;
    scan.first_pos = p;
  endfunction

  // advances the scan by one byte; returns 1 when a verdict is due
  function automatic bit scan_byte(logic [7:0] c, logic last, output result_t v);
    logic [PosBits-1:0] p;
    logic               esc;
    if (scan.pos != PosMax) scan.pos = scan.pos + 1'b1;
    p = scan.pos;
    if (!scan.found) begin
      if (scan.skip) begin
        scan.skip = 1'b0;
      end else if (scan.after_caret) begin
        scan.after_caret = 1'b0;
        if (c == ChDquote) flag_at(scan.quote != QuoteNone ? p - 1'b1 : p);
      end else begin
        esc = scan.after_bs;
        scan.after_bs = 1'b0;
        if (!(esc && c == ChDquote)) begin
          if (rules == ModeUnix) begin
            case (c)
              ChDollar, ChBackquote: begin
                if (scan.quote != QuoteSingle) flag_at(p);
              end
              ChSemicolon, ChPipe, ChAmpersand, ChNewline: begin
                if (scan.quote != QuoteSingle && !last) flag_at(p);
              end
              ChDquote: begin
                if (scan.quote == QuoteNone) scan.quote = QuoteDouble;
                else if (scan.quote == QuoteDouble) scan.quote = QuoteNone;
              end
              ChSquote: begin
                if (scan.quote == QuoteNone) scan.quote = QuoteSingle;
                else if (scan.quote == QuoteSingle) scan.quote = QuoteNone;
              end
              ChBackslash: begin
                if (last) flag_at(p);
                else if (scan.quote != QuoteSingle) scan.skip = 1'b1;
              end
              default: ;
            endcase
          end else begin
            case (c)
              ChGreater, ChLess, ChPipe, ChAmpersand, ChNewline: begin
                if (scan.quote == QuoteNone && !last) flag_at(p);
              end
              ChBackslash: begin
                if (!last) scan.after_bs = 1'b1;
              end
              ChDquote: begin
                scan.quote = (scan.quote == QuoteDouble) ? QuoteNone : QuoteDouble;
              end
              ChCaret: begin
                if (!last) scan.after_caret = 1'b1;
              end
              default: ;
            endcase
          end
        end
      end
    end
    v = '0;
    if (!last) return 1'b0;
    if (scan.found) begin
      v.unsafe = 1'b1;
      v.pos    = scan.first_pos;
    end else if (scan.quote != QuoteNone) begin
      v.unsafe = 1'b1;
      v.pos    = p;
    end
    scan = '0;
    return 1'b1;
  endfunction

  function automatic void note_error(string what, result_t want, result_t got);
    errors++;
    if (errors <= 10) begin
      $display("%s: expected unsafe=%0b pos=%0d, got unsafe=%0b pos=%0d",
               what, want.unsafe, want.pos, got.unsafe, got.pos);
    end
  endfunction

  always @(posedge clk_i) begin
    result_t got;
    result_t want;
    if (cfg_valid_i && cfg_ready_o) rules = shell_mode_e'(cfg_shell_mode_i);
    if (in_valid_i && in_ready_o) begin
      if (scan_byte(char_byte_i, last_byte_i, want)) begin
        verdict_q.push_back(item_typed ? item_verdict : want);
      end
    end
    if (out_valid_o && out_ready_i) begin
      got.unsafe = is_unsafe_o;
      got.pos    = unsafe_position_o;
      if (verdict_q.size() == 0) begin
        note_error("unexpected verdict", '0, got);
      end else begin
        want = verdict_q.pop_front();
        if (got.unsafe !== want.unsafe || got.pos !== want.pos) begin
          note_error("verdict mismatch", want, got);
        end
      end
    end
  end

  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    while (quiet < WatchdogLimit) begin
      @(posedge clk_i);
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) ||
          (cfg_valid_i && cfg_ready_o)) begin
        quiet = 0;
      end else begin
        quiet++;
      end
    end
    $display("shell_command_safety_checker_top test failed");
    $finish;
  end

  task automatic drive_byte(logic [7:0] c, logic last, logic typed, result_t v);
    while ($urandom_range(99) < gap_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i   <= 1'b1;
    char_byte_i  <= c;
    last_byte_i  <= last;
    item_typed   <= typed;
    item_verdict <= v;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
  endtask

  // holds off the sender until every verdict is out and the pipeline is empty
  task automatic settle_block();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (verdict_q.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic set_rules(shell_mode_e m);
    settle_block();
    cfg_valid_i      <= 1'b1;
    cfg_shell_mode_i <= m;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  function automatic logic [7:0] pick_char(int unsigned heat);
    logic [7:0] specials [12];
    specials = '{ChDollar, ChBackquote, ChSemicolon, ChPipe, ChAmpersand, ChNewline,
                 ChDquote, ChSquote, ChBackslash, ChGreater, ChLess, ChCaret};
    if ($urandom_range(99) < heat) return specials[$urandom_range(11)];
    if ($urandom_range(1) != 0) return 8'h61 + 8'($urandom_range(25));
    return 8'($urandom_range(255, 1));
  endfunction

  function automatic step_row_t byte_row(logic [7:0] c, logic last);
    step_row_t r;
    r = '{RowByte, ModeUnix, c, last, 1'b0, '0};
    return r;
  endfunction

  function automatic step_row_t typed_row(logic [7:0] c, logic unsafe, logic [15:0] pos);
    step_row_t r;
    r = '{RowByte, ModeUnix, c, 1'b1, 1'b1, '{unsafe, pos}};
    return r;
  endfunction

  function automatic step_row_t mode_row(shell_mode_e m);
    step_row_t r;
    r = '{RowMode, m, 8'h00, 1'b0, 1'b0, '0};
    return r;
  endfunction

  task automatic run_phase(int unsigned gap, int unsigned stall);
    int unsigned sent;
    int unsigned strings;
    int unsigned len;
    int unsigned heat;
    gap_pct   = gap;
    stall_pct <= stall;
    sent      = 0;
    strings   = 0;
    while (sent < PhaseBytes) begin
      if (strings % 30 == 0) set_rules(shell_mode_e'($urandom_range(1)));
      len = $urandom_range(12, 1);
      case ($urandom_range(2))
        0:       heat = 5;
        1:       heat = 25;
        default: heat = 60;
      endcase
      for (int k = 0; k < len; k++) drive_byte(pick_char(heat), k == len - 1, 1'b0, '0);
      sent += len;
      strings++;
    end
  endtask

  initial begin
    // unix rules after reset
    step_table.push_back(typed_row("a", 1'b0, 16'd0));
    step_table.push_back(typed_row(ChDollar, 1'b1, 16'd1));
    step_table.push_back(byte_row(8'hFF, 1'b0));
    step_table.push_back(byte_row(8'h00, 1'b0));
    step_table.push_back(typed_row(ChSemicolon, 1'b0, 16'd0));
    step_table.push_back(byte_row(ChSquote, 1'b0));
    step_table.push_back(byte_row(ChDollar, 1'b0));
    step_table.push_back(typed_row("x", 1'b1, 16'd3));
    step_table.push_back(byte_row(ChBackslash, 1'b0));
    step_table.push_back(byte_row(ChDollar, 1'b0));
    step_table.push_back(byte_row("b", 1'b1));
    step_table.push_back(byte_row("a", 1'b0));
    step_table.push_back(typed_row(ChBackslash, 1'b1, 16'd2));
    step_table.push_back(byte_row(ChAmpersand, 1'b0));
    step_table.push_back(byte_row(ChDquote, 1'b0));
    step_table.push_back(byte_row("z", 1'b1));
    // rules switched with a single quote open
    step_table.push_back(byte_row(ChSquote, 1'b0));
    step_table.push_back(mode_row(ModeWindows));
    step_table.push_back(byte_row(ChDquote, 1'b0));
    step_table.push_back(byte_row(ChDquote, 1'b1));
    // caret pending across a switch back to unix rules
    step_table.push_back(byte_row(ChCaret, 1'b0));
    step_table.push_back(mode_row(ModeUnix));
    step_table.push_back(byte_row(ChDquote, 1'b1));
    // caret then double quote inside an open double quote
    step_table.push_back(mode_row(ModeWindows));
    step_table.push_back(byte_row(ChDquote, 1'b0));
    step_table.push_back(byte_row(ChCaret, 1'b0));
    step_table.push_back(byte_row(ChDquote, 1'b1));

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (step_table[i]) begin
      if (step_table[i].kind == RowMode) begin
        set_rules(step_table[i].mode);
      end else begin
        drive_byte(step_table[i].ch, step_table[i].last, step_table[i].typed,
                   step_table[i].verdict);
      end
    end

    run_phase(0, 0);
    run_phase(51, 0);
    run_phase(0, 51);
    run_phase(12, 12);

    settle_block();
    if (verdict_q.size() != 0) begin
      errors += verdict_q.size();
      $display("%0d verdicts never arrived", verdict_q.size());
    end
    if (errors == 0) begin
      $display("shell_command_safety_checker_top test passed");
    end else begin
      $display("shell_command_safety_checker_top test failed");
    end
    $finish;
  end

endmodule
